>>> src/smc_pkg.sv
`default_nettype none
package smc_pkg;

  localparam int unsigned MAX_DIMS    = 8;
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned DIM_W  = 4;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned MEAN_W = 24;
  localparam int unsigned RES_W  = 48;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned DEV_W  = 25;
  localparam int unsigned PROD_W = 2 * DEV_W;
  localparam int unsigned CNT_OUT_W = 11;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_PUSH     = 3'd1;
  localparam logic [2:0] OP_FINISH   = 3'd2;
  localparam logic [2:0] OP_READ_MEAN = 3'd3;
  localparam logic [2:0] OP_READ_COV = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_TOO_FEW   = 3'd2;
  localparam logic [2:0] ST_RAGGED    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // zero acts as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dims(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] r;
    if (raw == '0) begin
      r = DIM_W'(1);
    end else if (raw > DIM_W'(MAX_DIMS)) begin
      r = DIM_W'(MAX_DIMS);
    end else begin
      r = raw;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/sample_mean_covariance_unit.sv
// Sample mean / unbiased covariance unit.
// Input channel (in_valid_i/in_ready_o) carries one request: clear, push a
// Q8.8 coordinate, finish, read a mean or read a covariance entry. Clear and
// push produce no response; the others produce exactly one response on the
// output channel (out_valid_o/out_ready_i).
// Push is handled in the idle state; reads pass a wait and an output state
// unless results are not ready. Finish walks the store with an accumulator,
// a multiplier and a shared radix-2 divider: a sample sum and a divide per
// dimension, then per covariance entry two mean reads, a deviation product
// per sample and a divide. A dimensions write recounts complete samples
// with the same divider and drops any finished results.
// One request is in flight at a time: in_ready_o and cfg_ready_o are low
// while a request is being worked on or its response is still waiting.
// A pending dimensions write is taken ahead of a request in the same cycle.
// A stalled receiver just holds the response register; nothing is lost.
// Reset empties the sample set, sets dimensions to 1 and clears results;
// store contents are not cleared.
`default_nettype none
module sample_mean_covariance_unit
  import smc_pkg::*;
#(
  parameter int unsigned MaxSamples = MAX_SAMPLES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [DIM_W-1:0]              cfg_dimensions_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  wire logic [IDX_W-1:0]              row_index_i,
  input  wire logic [IDX_W-1:0]              col_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [RES_W-1:0]            result_value_o,
  output logic [2:0]                         status_o,
  output logic [CNT_OUT_W-1:0]               sample_count_o
);

  localparam int unsigned StoreDepth = MAX_DIMS * MaxSamples;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned NW         = (MaxSamples > 2) ? $clog2(MaxSamples) : 1;
  localparam int unsigned DvsW       = NW + 16;
  localparam int unsigned CovAw      = 2 * IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MSUM_RD, S_MSUM_ACC, S_CMEAN_I, S_CMEAN_J, S_CMEAN_L,
    S_CRD, S_CDEV, S_CMUL, S_CACC, S_RD_WAIT, S_RD_OUT
  } state_e;

  typedef enum logic [1:0] {PH_COUNT, PH_MEAN, PH_COV} phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [DIM_W-1:0]    dims_q;
  logic [CntW-1:0]     ecount_q, nsamp_q, k_q;
  logic [IDX_W-1:0]    pos_q, i_q, j_q, row_q, col_q;
  logic                ovf_q, ready_q, op_cov_q;
  logic [StoreAw-1:0]  base_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [MEAN_W-1:0] mi_q, mj_q;
  logic signed [DEV_W-1:0]  dev_a_q, dev_b_q;
  logic signed [PROD_W-1:0] prod_q;

  // divider
  logic [ACC_W-1:0] dvd_q;
  logic [DvsW-1:0]  dvs_q, rem_q;
  logic [5:0]       dcnt_q;
  logic             dneg_q;
  logic [DvsW:0]    rem_sh;
  logic             qbit;
  logic [DvsW-1:0]  rem_nx;
  logic [ACC_W-1:0] q_nx, qs_nx;
  logic             div_last;

  // output register
  logic                    out_valid_q;
  logic signed [RES_W-1:0] res_q;
  logic [2:0]              status_q;
  logic [CNT_OUT_W-1:0]    cnt_out_q;

  // memories
  logic signed [SAMPLE_BITS-1:0] smp_mem [StoreDepth];
  logic signed [MEAN_W-1:0]      mean_mem [MAX_DIMS];
  logic signed [RES_W-1:0]       cov_mem [MAX_DIMS * MAX_DIMS];
  logic signed [SAMPLE_BITS-1:0] smp_a_q, smp_b_q;
  logic signed [MEAN_W-1:0]      mean_rd_q;
  logic signed [RES_W-1:0]       cov_rd_q;

  logic [DIM_W-1:0]    d_eff, d_m1;
  logic [StoreAw-1:0]  addr_a, addr_b;
  logic [IDX_W-1:0]    mean_ra;
  logic                in_acc, cfg_acc, push_we, mean_we, cov_we;
  logic [CntW-1:0]     cap;
  logic [31:0]         ns32;
  logic [CNT_OUT_W-1:0] cnt_sat;
  logic signed [ACC_W-1:0] acc_sum_nx, acc_cov_nx;
  logic                k_last, i_last, j_last;
  logic [NW-1:0]       nm1;

  assign d_eff   = clamp_dims(dims_q);
  assign d_m1    = d_eff - DIM_W'(1);
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign cap     = CntW'(d_eff) * CntW'(MaxSamples);
  assign push_we = in_acc && (opcode_i == OP_PUSH) && !cfg_acc
                   && (ecount_q < cap) && (ecount_q < CntW'(StoreDepth));

  assign ns32    = 32'(nsamp_q);
  assign cnt_sat = (ns32 > 32'd2047) ? CNT_OUT_W'(2047) : ns32[CNT_OUT_W-1:0];

  assign addr_a  = base_q + StoreAw'(i_q);
  assign addr_b  = base_q + StoreAw'(j_q);
  assign mean_ra = (state_q == S_CMEAN_J) ? j_q : ((state_q == S_RD_WAIT) ? row_q : i_q);

  assign k_last  = (k_q == nsamp_q - CntW'(1));
  assign i_last  = ({1'b0, i_q} == d_m1);
  assign j_last  = ({1'b0, j_q} == d_m1);
  assign nm1     = NW'(nsamp_q - CntW'(1));

  assign acc_sum_nx = acc_q + ACC_W'(smp_a_q);
  assign acc_cov_nx = acc_q + ACC_W'(prod_q);

  // one restoring divide step per cycle
  assign rem_sh   = {rem_q, dvd_q[ACC_W-1]};
  assign qbit     = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx   = qbit ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
  assign q_nx     = {dvd_q[ACC_W-2:0], qbit};
  assign qs_nx    = dneg_q ? (ACC_W'(0) - q_nx) : q_nx;
  assign div_last = (state_q == S_DIV) && (dcnt_q == 6'd63);

  assign mean_we = div_last && (phase_q == PH_MEAN);
  assign cov_we  = div_last && (phase_q == PH_COV);

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      smp_mem[ecount_q[StoreAw-1:0]] <= sample_value_i;
    end
    smp_a_q <= smp_mem[addr_a];
    smp_b_q <= smp_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[i_q] <= qs_nx[MEAN_W-1:0];
    end
    mean_rd_q <= mean_mem[mean_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cov_we) begin
      cov_mem[{i_q, j_q}] <= qs_nx[RES_W-1:0];
    end
    cov_rd_q <= cov_mem[CovAw'({row_q, col_q})];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_COUNT;
      dims_q      <= DIM_W'(1);
      ecount_q    <= '0;
      nsamp_q     <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      base_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_acc) begin
            // recount complete samples for the new geometry
            dims_q  <= cfg_dimensions_i;
            ready_q <= 1'b0;
            phase_q <= PH_COUNT;
            dvd_q   <= ACC_W'(ecount_q);
            dvs_q   <= DvsW'(clamp_dims(cfg_dimensions_i));
            dneg_q  <= 1'b0;
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else if (in_acc) begin
            row_q    <= row_index_i;
            col_q    <= col_index_i;
            op_cov_q <= (opcode_i == OP_READ_COV);
            cnt_out_q <= cnt_sat;
            res_q    <= '0;
            unique case (opcode_i)
              OP_CLEAR: begin
                ecount_q <= '0;
                nsamp_q  <= '0;
                pos_q    <= '0;
                ovf_q    <= 1'b0;
                ready_q  <= 1'b0;
              end
              OP_PUSH: begin
                ready_q <= 1'b0;
                if (push_we) begin
                  ecount_q <= ecount_q + CntW'(1);
                  if ({1'b0, pos_q} == d_m1) begin
                    pos_q   <= '0;
                    nsamp_q <= nsamp_q + CntW'(1);
                  end else begin
                    pos_q <= pos_q + IDX_W'(1);
                  end
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_FINISH: begin
                ready_q <= 1'b0;
                if (ovf_q || (nsamp_q > CntW'(MaxSamples))) begin
                  status_q    <= ST_OVERFLOW;
                  out_valid_q <= 1'b1;
                end else if (pos_q != '0) begin
                  status_q    <= ST_RAGGED;
                  out_valid_q <= 1'b1;
                end else if (nsamp_q < CntW'(2)) begin
                  status_q    <= ST_TOO_FEW;
                  out_valid_q <= 1'b1;
                end else begin
                  i_q     <= '0;
                  k_q     <= '0;
                  base_q  <= '0;
                  acc_q   <= '0;
                  state_q <= S_MSUM_RD;
                end
              end
              OP_READ_MEAN, OP_READ_COV: begin
                if (!ready_q) begin
                  status_q    <= ST_NOT_READY;
                  out_valid_q <= 1'b1;
                end else begin
                  status_q <= ST_OK;
                  state_q  <= S_RD_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_RD_WAIT: state_q <= S_RD_OUT;

        S_RD_OUT: begin
          if (!op_cov_q) begin
            res_q <= ({1'b0, row_q} < d_eff) ? RES_W'(mean_rd_q) : '0;
          end else begin
            res_q <= (({1'b0, row_q} < d_eff) && ({1'b0, col_q} < d_eff)) ? cov_rd_q : '0;
          end
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end

        S_MSUM_RD: state_q <= S_MSUM_ACC;

        S_MSUM_ACC: begin
          acc_q  <= acc_sum_nx;
          base_q <= base_q + StoreAw'(d_eff);
          k_q    <= k_q + CntW'(1);
          if (k_last) begin
            // mean = (sum << 8) / n
            phase_q <= PH_MEAN;
            dneg_q  <= acc_sum_nx[ACC_W-9];
            dvd_q   <= acc_sum_nx[ACC_W-9] ? (ACC_W'(0) - {acc_sum_nx[ACC_W-9:0], 8'b0})
                                           : {acc_sum_nx[ACC_W-9:0], 8'b0};
            dvs_q   <= DvsW'(nsamp_q);
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else begin
            state_q <= S_MSUM_RD;
          end
        end

        S_CMEAN_I: state_q <= S_CMEAN_J;

        S_CMEAN_J: begin
          mi_q    <= mean_rd_q;
          state_q <= S_CMEAN_L;
        end

        S_CMEAN_L: begin
          mj_q    <= mean_rd_q;
          state_q <= S_CRD;
        end

        S_CRD: state_q <= S_CDEV;

        S_CDEV: begin
          dev_a_q <= {smp_a_q[SAMPLE_BITS-1], smp_a_q, 8'b0} - DEV_W'(mi_q);
          dev_b_q <= {smp_b_q[SAMPLE_BITS-1], smp_b_q, 8'b0} - DEV_W'(mj_q);
          state_q <= S_CMUL;
        end

        S_CMUL: begin
          prod_q  <= dev_a_q * dev_b_q;
          state_q <= S_CACC;
        end

        S_CACC: begin
          acc_q  <= acc_cov_nx;
          base_q <= base_q + StoreAw'(d_eff);
          k_q    <= k_q + CntW'(1);
          if (k_last) begin
            // entry = acc / ((n - 1) << 16)
            phase_q <= PH_COV;
            dneg_q  <= acc_cov_nx[ACC_W-1];
            dvd_q   <= acc_cov_nx[ACC_W-1] ? (ACC_W'(0) - acc_cov_nx) : acc_cov_nx;
            dvs_q   <= {nm1, 16'b0};
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else begin
            state_q <= S_CRD;
          end
        end

        S_DIV: begin
          dvd_q  <= q_nx;
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (div_last) begin
            acc_q  <= '0;
            k_q    <= '0;
            base_q <= '0;
            unique case (phase_q)
              PH_COUNT: begin
                nsamp_q <= q_nx[CntW-1:0];
                pos_q   <= rem_nx[IDX_W-1:0];
                state_q <= S_IDLE;
              end
              PH_MEAN: begin
                if (i_last) begin
                  i_q     <= '0;
                  j_q     <= '0;
                  state_q <= S_CMEAN_I;
                end else begin
                  i_q     <= i_q + IDX_W'(1);
                  state_q <= S_MSUM_RD;
                end
              end
              PH_COV: begin
                if (j_last) begin
                  j_q <= '0;
                  if (i_last) begin
                    ready_q     <= 1'b1;
                    status_q    <= ST_OK;
                    res_q       <= '0;
                    out_valid_q <= 1'b1;
                    state_q     <= S_IDLE;
                  end else begin
                    i_q     <= i_q + IDX_W'(1);
                    state_q <= S_CMEAN_I;
                  end
                end else begin
                  j_q     <= j_q + IDX_W'(1);
                  state_q <= S_CMEAN_I;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign sample_count_o = cnt_out_q;

endmodule
`default_nettype wire
